// File: sv/wsd_pkg.sv
// ---------------------------------------------------------------------------
// wsd_pkg: shared definitions for the websocket frame deframer
// Event codes, opcodes, length codes, queue sizing, the result transaction type and queue status.
// ---------------------------------------------------------------------------
package wsd_pkg;

    localparam int LENGTH_BITS = 64;

    localparam logic [2:0] EV_TEXT_BYTE  = 3'd0;
    localparam logic [2:0] EV_EMPTY_END  = 3'd1;
    localparam logic [2:0] EV_SEND_PONG  = 3'd2;
    localparam logic [2:0] EV_CLOSE      = 3'd3;
    localparam logic [2:0] EV_BINARY_ERR = 3'd4;
    localparam logic [2:0] EV_MASK_ERR   = 3'd5;
    localparam logic [2:0] EV_STRAY_CONT = 3'd6;
    localparam logic [2:0] EV_PONG_SEEN  = 3'd7;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  data_byte;
        logic        message_last;
        logic [15:0] close_code;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// File: sv/wsd_front.sv
// ---------------------------------------------------------------------------
// wsd_front: frame header parser and byte classifier
// Walks header, extended length, masking key and payload, one byte per
// transaction, and pushes at most one result into the queue per byte.
// ---------------------------------------------------------------------------
module wsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  wsd_pkg::t_queue_status i_q_status,
    output logic              o_push,
    output wsd_pkg::t_result  o_push_data
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    logic [2:0]             r_phase, n_phase;
    logic [3:0]             r_op, n_op;
    logic                   r_final, n_final;
    logic                   r_masked, n_masked;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [2:0]             r_cnt, n_cnt;
    logic [3:0]             r_frag, n_frag;
    logic [15:0]            r_status, n_status;
    logic [1:0]             r_seen, n_seen;

    logic     accept;
    logic     len_done;
    logic     hdr_done;
    logic     fr_end;
    logic     emit;
    t_result  res;

    assign o_rx_ready = !i_q_status.full;
    assign accept     = i_rx_valid && o_rx_ready;

    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_final  = r_final;
        n_masked = r_masked;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_frag   = r_frag;
        n_status = r_status;
        n_seen   = r_seen;
        len_done = 1'b0;
        hdr_done = 1'b0;
        fr_end   = 1'b0;
        emit     = 1'b0;
        res      = '0;

        case (r_phase)
            PH_HDR0: begin
                n_final  = i_rx_byte[7];
                n_op     = i_rx_byte[3:0];
                n_status = '0;
                n_seen   = '0;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_rx_byte[7];
                n_rem    = '0;
                if (i_rx_byte[6:0] == LEN7_EXT16) begin
                    n_phase = PH_EXT;
                    n_cnt   = 3'd1;
                end else if (i_rx_byte[6:0] == LEN7_EXT64) begin
                    n_phase = PH_EXT;
                    n_cnt   = 3'd7;
                end else begin
                    n_rem    = {{(LENGTH_BITS-7){1'b0}}, i_rx_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_rem = {r_rem[LENGTH_BITS-9:0], i_rx_byte};
                if (r_cnt == 3'd0) begin
                    len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_KEY: begin
                if (r_cnt == 3'd0) begin
                    hdr_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            PH_DATA: begin
                n_rem = r_rem - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                if (!r_masked && r_op == OP_TEXT) begin
                    emit             = 1'b1;
                    res.event_kind   = EV_TEXT_BYTE;
                    res.data_byte    = i_rx_byte;
                    res.message_last = (n_rem == '0) && r_final;
                    if (n_rem == '0) begin
                        n_phase = PH_HDR0;
                    end
                end else begin
                    if (!r_masked && r_op == OP_CLOSE && r_seen != 2'd2) begin
                        n_status = {r_status[7:0], i_rx_byte};
                        n_seen   = r_seen + 2'd1;
                    end
                    if (n_rem == '0) begin
                        fr_end = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase

        if (len_done) begin
            if (n_masked) begin
                n_phase = PH_KEY;
                n_cnt   = 3'd3;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            if (!n_masked) begin
                if (n_op == OP_CONT) begin
                    n_op = r_frag;
                    if (n_final) begin
                        n_frag = OP_CONT;
                    end
                end else if (!n_final && r_frag == OP_CONT) begin
                    n_frag = n_op;
                end
            end
            if (n_rem == '0) begin
                fr_end = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end

        if (fr_end) begin
            n_phase = PH_HDR0;
            if (n_masked) begin
                emit           = 1'b1;
                res.event_kind = EV_MASK_ERR;
            end else if (n_final) begin
                emit = 1'b1;
                case (n_op)
                    OP_CONT:   res.event_kind = EV_STRAY_CONT;
                    OP_TEXT: begin
                        res.event_kind   = EV_EMPTY_END;
                        res.message_last = 1'b1;
                    end
                    OP_BINARY: res.event_kind = EV_BINARY_ERR;
                    OP_CLOSE: begin
                        res.event_kind = EV_CLOSE;
                        res.close_code = (n_seen == 2'd2) ? n_status : 16'd0;
                    end
                    OP_PING:   res.event_kind = EV_SEND_PONG;
                    OP_PONG:   res.event_kind = EV_PONG_SEEN;
                    default:   emit = 1'b0;
                endcase
            end
        end
    end

    assign o_push      = accept && emit;
    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_op     <= '0;
            r_final  <= 1'b0;
            r_masked <= 1'b0;
            r_rem    <= '0;
            r_cnt    <= '0;
            r_frag   <= OP_CONT;
            r_status <= '0;
            r_seen   <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_op     <= n_op;
            r_final  <= n_final;
            r_masked <= n_masked;
            r_rem    <= n_rem;
            r_cnt    <= n_cnt;
            r_frag   <= n_frag;
            r_status <= n_status;
            r_seen   <= n_seen;
        end
    end

endmodule

// File: sv/wsd_queue.sv
// ---------------------------------------------------------------------------
// wsd_queue: short result queue
// Decouples the parser from the output stage so that each may stall alone.
// ---------------------------------------------------------------------------
module wsd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  wsd_pkg::t_result       i_push_data,
    input  logic                   i_pop,
    output wsd_pkg::t_result       o_head,
    output wsd_pkg::t_queue_status o_status
);
    import wsd_pkg::*;

    t_result              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

// File: sv/wsd_back.sv
// ---------------------------------------------------------------------------
// wsd_back: result output stage
// Holds one result transaction in a register and refills it from the queue.
// ---------------------------------------------------------------------------
module wsd_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wsd_pkg::t_result       i_head,
    input  wsd_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    output logic                   o_ev_valid,
    input  logic                   i_ev_ready,
    output logic [2:0]             o_event_kind,
    output logic [7:0]             o_data_byte,
    output logic                   o_message_last,
    output logic [15:0]            o_close_code
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    load;

    assign load  = !r_valid || i_ev_ready;
    assign o_pop = load && !i_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_ev_valid     = r_valid;
    assign o_event_kind   = r_res.event_kind;
    assign o_data_byte    = r_res.data_byte;
    assign o_message_last = r_res.message_last;
    assign o_close_code   = r_res.close_code;

endmodule

// File: sv/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser
// Takes one stream byte per transaction and gives text bytes and frame
// events. One byte is taken every cycle while the four-entry result queue
// has room; a result is written into the queue and from there loaded into
// the output register. The rate is set by the combinational parser step,
// whose longest path is the decrement and zero test of the 64-bit length.
// ---------------------------------------------------------------------------
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_ev_valid,
    input  logic        i_ev_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_message_last,
    output logic [15:0] o_close_code
);
    import wsd_pkg::*;

    logic          push;
    t_result       push_data;
    logic          pop;
    t_result       head;
    t_queue_status q_status;

    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    wsd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    wsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_ev_valid     (o_ev_valid),
        .i_ev_ready     (i_ev_ready),
        .o_event_kind   (o_event_kind),
        .o_data_byte    (o_data_byte),
        .o_message_last (o_message_last),
        .o_close_code   (o_close_code)
    );

endmodule

// File: verif/websocket_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_deframer_tb: self-checking testbench for the frame deframer
// Feeds directed and random WebSocket frame streams one byte per transaction.
// It predicts text bytes and frame events in step with the accepted bytes and
// checks every result transaction, field by field, in order of arrival.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST, PH_SECOND, PH_EXTLEN, PH_MASKKEY, PH_PAYLOAD
    } parse_phase_e;

    typedef enum int {LF_SHORT, LF_EXT16, LF_EXT64} len_form_e;

    localparam logic [3:0] OP_RSVD_DATA = 4'h3;
    localparam logic [3:0] OP_RSVD_CTRL = 4'hF;

    localparam int STREAM_BYTES = 1850;
    localparam int CALM_TAIL    = 300;
    localparam int HOLD_AT      = 700;
    localparam int HOLD_CYCLES  = 100;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_rx_valid     = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte      = 8'h00;
    logic        o_ev_valid;
    logic        i_ev_ready     = 1'b0;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_data_byte;
    logic        o_message_last;
    logic [15:0] o_close_code;

    logic        calm           = 1'b0;

    logic [7:0]  byte_stim[$];
    t_result     pending_events[$];
    int          mismatches     = 0;

    int          gap_left       = 0;
    int          stall_left     = 0;
    int          hold_left      = 0;
    int          seen_bytes     = 0;
    bit          held           = 1'b0;

    // deframer state mirror
    parse_phase_e           rx_phase;
    logic [3:0]             rx_opcode;
    logic                   rx_fin;
    logic                   rx_masked;
    logic [LENGTH_BITS-1:0] rx_left;
    logic [2:0]             rx_hdr_left;
    logic [3:0]             msg_opcode;
    logic [15:0]            close_acc;
    logic [1:0]             close_cnt;

    websocket_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_ev_valid     (o_ev_valid),
        .i_ev_ready     (i_ev_ready),
        .o_event_kind   (o_event_kind),
        .o_data_byte    (o_data_byte),
        .o_message_last (o_message_last),
        .o_close_code   (o_close_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic push_event(input logic [2:0] kind, input logic [7:0] data,
                              input logic last, input logic [15:0] code);
        t_result r;
        r.event_kind   = kind;
        r.data_byte    = data;
        r.message_last = last;
        r.close_code   = code;
        pending_events.push_back(r);
    endtask

    task automatic finish_frame();
        rx_phase = PH_FIRST;
        if (rx_masked) begin
            push_event(EV_MASK_ERR, 8'h00, 1'b0, 16'h0000);
        end else if (rx_fin) begin
            case (rx_opcode)
                OP_CONT:   push_event(EV_STRAY_CONT, 8'h00, 1'b0, 16'h0000);
                OP_TEXT:   push_event(EV_EMPTY_END, 8'h00, 1'b1, 16'h0000);
                OP_BINARY: push_event(EV_BINARY_ERR, 8'h00, 1'b0, 16'h0000);
                OP_CLOSE:  push_event(EV_CLOSE, 8'h00, 1'b0,
                                      (close_cnt >= 2'd2) ? close_acc : 16'h0000);
                OP_PING:   push_event(EV_SEND_PONG, 8'h00, 1'b0, 16'h0000);
                OP_PONG:   push_event(EV_PONG_SEEN, 8'h00, 1'b0, 16'h0000);
                default:   rx_phase = PH_FIRST;
            endcase
        end
    endtask

    task automatic resolve_header();
        if (!rx_masked) begin
            if (rx_opcode == OP_CONT) begin
                rx_opcode = msg_opcode;
                if (rx_fin) msg_opcode = OP_CONT;
            end else if (!rx_fin && msg_opcode == OP_CONT) begin
                msg_opcode = rx_opcode;
            end
        end
        if (rx_left == '0) finish_frame();
        else rx_phase = PH_PAYLOAD;
    endtask

    task automatic length_known();
        if (rx_masked) begin
            rx_phase    = PH_MASKKEY;
            rx_hdr_left = 3'd3;
        end else begin
            resolve_header();
        end
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic last;
        case (rx_phase)
            PH_FIRST: begin
                rx_fin    = b[7];
                rx_opcode = b[3:0];
                close_acc = 16'h0000;
                close_cnt = 2'd0;
                rx_phase  = PH_SECOND;
            end
            PH_SECOND: begin
                rx_masked = b[7];
                rx_left   = '0;
                if (b[6:0] == LEN7_EXT16) begin
                    rx_phase    = PH_EXTLEN;
                    rx_hdr_left = 3'd1;
                end else if (b[6:0] == LEN7_EXT64) begin
                    rx_phase    = PH_EXTLEN;
                    rx_hdr_left = 3'd7;
                end else begin
                    rx_left = LENGTH_BITS'(b[6:0]);
                    length_known();
                end
            end
            PH_EXTLEN: begin
                rx_left = {rx_left[LENGTH_BITS-9:0], b};
                if (rx_hdr_left == 3'd0) length_known();
                else rx_hdr_left = rx_hdr_left - 3'd1;
            end
            PH_MASKKEY: begin
                if (rx_hdr_left == 3'd0) resolve_header();
                else rx_hdr_left = rx_hdr_left - 3'd1;
            end
            PH_PAYLOAD: begin
                rx_left = rx_left - 1'b1;
                if (!rx_masked && rx_opcode == OP_TEXT) begin
                    last = (rx_left == '0);
                    if (last) rx_phase = PH_FIRST;
                    push_event(EV_TEXT_BYTE, b, last && rx_fin, 16'h0000);
                end else begin
                    if (!rx_masked && rx_opcode == OP_CLOSE && close_cnt < 2'd2) begin
                        close_acc = {close_acc[7:0], b};
                        close_cnt = close_cnt + 2'd1;
                    end
                    if (rx_left == '0) finish_frame();
                end
            end
            default: rx_phase = PH_FIRST;
        endcase
    endtask

    task automatic push_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic msk, input int len, input len_form_e form);
        logic [63:0] l64;
        l64 = 64'(len);
        byte_stim.push_back({fin, rsv, op});
        case (form)
            LF_SHORT: byte_stim.push_back({msk, l64[6:0]});
            LF_EXT16: begin
                byte_stim.push_back({msk, LEN7_EXT16});
                byte_stim.push_back(l64[15:8]);
                byte_stim.push_back(l64[7:0]);
            end
            default: begin
                byte_stim.push_back({msk, LEN7_EXT64});
                for (int i = 7; i >= 0; i--) byte_stim.push_back(l64[8*i +: 8]);
            end
        endcase
        if (msk) repeat (4) byte_stim.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++) byte_stim.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic pick_length(output int len, output len_form_e form);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            form = LF_SHORT;
            len  = $urandom_range(0, 12);
        end else if (r < 78) begin
            form = LF_SHORT;
            len  = $urandom_range(13, 125);
        end else if (r < 92) begin
            form = LF_EXT16;
            len  = (r < 85) ? $urandom_range(0, 20) : $urandom_range(126, 300);
        end else begin
            form = LF_EXT64;
            len  = $urandom_range(0, 24);
        end
    endtask

    task automatic push_control();
        logic [3:0] op;
        int         sel;
        sel = $urandom_range(0, 2);
        op  = (sel == 0) ? OP_PING : (sel == 1) ? OP_PONG : OP_CLOSE;
        push_frame(1'b1, 3'b000, op, $urandom_range(0, 11) == 0, $urandom_range(0, 5), LF_SHORT);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver: byte transactions from the stimulus queue
    always @(posedge i_clk) begin : drive_blk
        logic       nv;
        logic [7:0] nb;
        nv = i_rx_valid;
        nb = i_rx_byte;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_stim.size() > 0) begin
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        gap_left = $urandom_range(0, 2);
                    end else begin
                        nv = 1'b1;
                        nb = byte_stim.pop_front();
                    end
                end
            end
        end
        i_rx_valid <= nv;
        i_rx_byte  <= nb;
        calm       <= (byte_stim.size() < CALM_TAIL);
    end

    // receiver: random stall bursts plus one long hold-off
    always @(posedge i_clk) begin : recv_blk
        logic nr;
        nr = 1'b1;
        if (!i_rst_n) begin
            nr = 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready) seen_bytes++;
            if (!held && seen_bytes >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                nr = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                nr = 1'b0;
            end
        end
        i_ev_ready <= nr;
    end

    // monitor: advance the mirror on each byte, then check the result transaction
    always @(posedge i_clk) begin : score_blk
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            rx_phase    = PH_FIRST;
            rx_opcode   = OP_CONT;
            rx_fin      = 1'b0;
            rx_masked   = 1'b0;
            rx_left     = '0;
            rx_hdr_left = 3'd0;
            msg_opcode  = OP_CONT;
            close_acc   = 16'h0000;
            close_cnt   = 2'd0;
        end else begin
            if (i_rx_valid && o_rx_ready) deframe_byte(i_rx_byte);
            if (o_ev_valid && i_ev_ready) begin
                got.event_kind   = o_event_kind;
                got.data_byte    = o_data_byte;
                got.message_last = o_message_last;
                got.close_code   = o_close_code;
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d data 0x%0h last %0d code 0x%0h",
                             $time, got.event_kind, got.data_byte, got.message_last,
                             got.close_code);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_kind", want.event_kind, got.event_kind);
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("message_last", want.message_last, got.message_last);
                    check_field("close_code", want.close_code, got.close_code);
                end
            end
        end
    end

    initial begin : main_blk
        bit          timed_out;
        int unsigned cycle_limit;
        int          len;
        int          frags;
        int          r;
        len_form_e   form;
        logic [3:0]  msg_op;
        timed_out = 1'b0;

        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 1, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 2, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_PING, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_PONG, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, 2, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, 3, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, 1, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_RSVD_DATA, 1'b0, 1, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_RSVD_CTRL, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CONT, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CONT, 1'b0, 2, LF_SHORT);
        // fragmented text with a ping in between and a second opening attempt
        push_frame(1'b0, 3'b000, OP_TEXT, 1'b0, 2, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_PING, 1'b0, 0, LF_SHORT);
        push_frame(1'b0, 3'b000, OP_CONT, 1'b0, 1, LF_SHORT);
        push_frame(1'b0, 3'b000, OP_BINARY, 1'b0, 1, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CONT, 1'b0, 2, LF_SHORT);
        push_frame(1'b0, 3'b000, OP_BINARY, 1'b0, 1, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CONT, 1'b0, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b1, 2, LF_SHORT);
        push_frame(1'b0, 3'b000, OP_TEXT, 1'b1, 0, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, 0, LF_EXT64);
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 125, LF_SHORT);
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 130, LF_EXT16);
        push_frame(1'b1, 3'b000, OP_PING, 1'b0, 0, LF_EXT16);
        push_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 3, LF_EXT64);
        push_frame(1'b1, 3'b111, OP_TEXT, 1'b0, 1, LF_SHORT);

        while (byte_stim.size() < STREAM_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                frags  = $urandom_range(1, 4);
                msg_op = ($urandom_range(0, 3) == 0) ? OP_BINARY : OP_TEXT;
                for (int f = 0; f < frags; f++) begin
                    pick_length(len, form);
                    push_frame(f == frags - 1, 3'b000, (f == 0) ? msg_op : OP_CONT,
                               $urandom_range(0, 11) == 0, len, form);
                    if (f < frags - 1 && $urandom_range(0, 3) == 0) push_control();
                end
            end else if (r < 86) begin
                push_control();
            end else begin
                pick_length(len, form);
                push_frame($urandom_range(0, 1), 3'($urandom_range(0, 7)),
                           4'($urandom_range(0, 15)), $urandom_range(0, 1), len, form);
            end
        end

        cycle_limit = 40 * byte_stim.size() + 20000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                repeat (cycle_limit) @(posedge i_clk);
                timed_out = 1'b1;
            end
            begin
                do @(negedge i_clk);
                while (byte_stim.size() != 0 || i_rx_valid || pending_events.size() != 0);
                repeat (16) @(negedge i_clk);
            end
        join_any
        disable fork;

        if (!timed_out && mismatches == 0 && pending_events.size() == 0) begin
            $display("** websocket_frame_deframer: PASSED **");
        end else begin
            $display("** websocket_frame_deframer: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
sv/wsd_pkg.sv
sv/wsd_front.sv
sv/wsd_queue.sv
sv/wsd_back.sv
sv/websocket_frame_deframer.sv
verif/websocket_frame_deframer_tb.sv
